@@ rtl/core/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg: shared constants and types for the plane side classifier
// Object kinds, side codes, configuration register indexes, default widths
// and the control struct that the top level hands to the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  // default field widths
  localparam int COORD_BITS_DEF       = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int TOL_BITS             = 16;
  localparam int KIND_BITS            = 2;
  localparam int SIDE_BITS            = 2;
  localparam int CFG_INDEX_BITS       = 3;
  localparam int OUT_DATA_BITS        = 8;
  localparam int NUM_AXES             = 3;

  // object kinds
  localparam logic [KIND_BITS-1:0] KIND_POINT  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SPHERE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_BOX    = 2'd2;

  // classification codes
  localparam logic [SIDE_BITS-1:0] SIDE_FRONT  = 2'd0;
  localparam logic [SIDE_BITS-1:0] SIDE_BEHIND = 2'd1;
  localparam logic [SIDE_BITS-1:0] SIDE_ON     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_X  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = 3'd4;

  // load enables for the two merge registers
  typedef struct packed {
    logic sum_en;
    logic cmp_en;
  } merge_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/psc_lane.sv @@
// ----------------------------------------------------------------------------
// psc_lane: one axis lane of the plane side classifier
// For boxes, picks the corner coordinates by the sign of the normal component and
// forms the minimum and maximum projection products, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_lane #(
  parameter int COORD_BITS       = psc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = psc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        en,
  input  logic [psc_pkg::KIND_BITS-1:0]               kind,
  input  logic signed [NORMAL_FRAC_BITS+1:0]          normal,
  input  logic signed [COORD_BITS-1:0]                pos,
  input  logic signed [COORD_BITS-1:0]                far,
  output logic signed [COORD_BITS+NORMAL_FRAC_BITS+1:0] prod_lo,
  output logic signed [COORD_BITS+NORMAL_FRAC_BITS+1:0] prod_hi
);
  import psc_pkg::*;

  localparam int PROD_W = COORD_BITS + NORMAL_FRAC_BITS + 2;

  logic                         swap;
  logic signed [COORD_BITS-1:0] lo_coord;
  logic signed [COORD_BITS-1:0] hi_coord;

  // boxes with a non-positive component take the far corner for the minimum
  assign swap     = (kind == KIND_BOX) && !(normal > 0);
  assign lo_coord = swap ? far : pos;
  assign hi_coord = swap ? pos : far;

  // projection products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_lo <= PROD_W'(normal) * PROD_W'(lo_coord);
      prod_hi <= PROD_W'(normal) * PROD_W'(hi_coord);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/psc_merge.sv @@
// ----------------------------------------------------------------------------
// psc_merge: merging stage of the plane side classifier
// Adds the three lane products and compares the totals against the
// front and behind thresholds to give the side code.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_merge #(
  parameter int COORD_BITS       = psc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = psc_pkg::NORMAL_FRAC_BITS_DEF,
  localparam int PROD_W          = COORD_BITS + NORMAL_FRAC_BITS + 2,
  localparam int CMP_W           = PROD_W + 2
) (
  input  logic                          clk,
  input  psc_pkg::merge_ctl_t           ctl,
  input  logic [psc_pkg::KIND_BITS-1:0] kind,
  input  logic signed [PROD_W-1:0]      prod_lo [psc_pkg::NUM_AXES],
  input  logic signed [PROD_W-1:0]      prod_hi [psc_pkg::NUM_AXES],
  input  logic signed [CMP_W-1:0]       thr_front,
  input  logic signed [CMP_W-1:0]       thr_behind,
  output logic [psc_pkg::SIDE_BITS-1:0] side
);
  import psc_pkg::*;

  logic signed [CMP_W-1:0]  lo_ext [NUM_AXES];
  logic signed [CMP_W-1:0]  hi_ext [NUM_AXES];
  logic signed [CMP_W-1:0]  lo_sum;
  logic signed [CMP_W-1:0]  hi_sum;
  logic signed [CMP_W-1:0]  thr_front_c;
  logic signed [CMP_W-1:0]  thr_behind_c;
  logic [KIND_BITS-1:0]     kind_c;
  logic signed [CMP_W-1:0]  behind_val;
  logic                     strict;
  logic                     is_front;
  logic                     is_behind;
  logic [SIDE_BITS-1:0]     side_next;

  // sign-extend lane products
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      lo_ext[i] = {{(CMP_W-PROD_W){prod_lo[i][PROD_W-1]}}, prod_lo[i]};
      hi_ext[i] = {{(CMP_W-PROD_W){prod_hi[i][PROD_W-1]}}, prod_hi[i]};
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      lo_sum       <= lo_ext[0] + lo_ext[1] + lo_ext[2];
      hi_sum       <= hi_ext[0] + hi_ext[1] + hi_ext[2];
      thr_front_c  <= thr_front;
      thr_behind_c <= thr_behind;
      kind_c       <= kind;
    end
  end

  // compare: points use a strict band, spheres and boxes an inclusive one
  always_comb begin
    strict     = (kind_c == KIND_POINT);
    behind_val = (kind_c == KIND_BOX) ? hi_sum : lo_sum;
    is_front   = strict ? (lo_sum > thr_front_c) : (lo_sum >= thr_front_c);
    is_behind  = strict ? (behind_val < thr_behind_c) : (behind_val <= thr_behind_c);
    if (!((kind_c == KIND_POINT) || (kind_c == KIND_SPHERE) || (kind_c == KIND_BOX))) begin
      side_next = SIDE_ON;
    end else if (is_front) begin
      side_next = SIDE_FRONT;
    end else if (is_behind) begin
      side_next = SIDE_BEHIND;
    end else begin
      side_next = SIDE_ON;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      side <= side_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/plane_side_classifier.sv @@
// ----------------------------------------------------------------------------
// plane_side_classifier: point, sphere and box against one plane
// Top level: stream ports, configuration registers, input register,
// three axis lanes, threshold stage and the merging stage.
// ----------------------------------------------------------------------------
// The block takes one word per clock and returns one side code per word,
// in order, after the word passes the input register, lane products, lane
// sum and compare register. Throughput is one word per cycle
// for as long as the output side takes words; each stage holds when the one
// after it is full and stalled, so a stall at the output reaches the input
// through the chain of stage enables. Each of the three axis lanes has two
// signed multipliers of normal width by coordinate width. Configuration is
// written through the cfg port, which is always ready; write it only while
// no word is in flight.
`default_nettype none

module plane_side_classifier #(
  parameter int COORD_BITS       = psc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = psc_pkg::NORMAL_FRAC_BITS_DEF,
  localparam int NORMAL_BITS     = NORMAL_FRAC_BITS + 2,
  localparam int IN_FIELD_BITS   = 7 * COORD_BITS - 1,
  localparam int IN_DATA_BITS    = ((IN_FIELD_BITS + 7) / 8) * 8,
  localparam int CFG_DATA_BITS   = (COORD_BITS > NORMAL_BITS) ?
                                   ((COORD_BITS > psc_pkg::TOL_BITS) ?
                                    COORD_BITS : psc_pkg::TOL_BITS) :
                                   ((NORMAL_BITS > psc_pkg::TOL_BITS) ?
                                    NORMAL_BITS : psc_pkg::TOL_BITS)
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x, pos_y, pos_z, far_x, far_y, far_z, radius, zero pad
  input  logic [IN_DATA_BITS-1:0]             s_axis_tdata,
  // kind
  input  logic [psc_pkg::KIND_BITS-1:0]       s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // side, zero pad
  output logic [psc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]            cfg_data
);
  import psc_pkg::*;

  localparam int PROD_W = COORD_BITS + NORMAL_BITS;
  localparam int CMP_W  = PROD_W + 2;
  localparam int DREF_W = COORD_BITS + NORMAL_FRAC_BITS;
  localparam int RAD_W  = COORD_BITS - 1;

  // configuration registers
  logic signed [NORMAL_BITS-1:0] normal [NUM_AXES];
  logic signed [COORD_BITS-1:0]  plane_offset;
  logic [TOL_BITS-1:0]           tolerance;

  // pipeline valids and enables
  logic valid_a, valid_b, valid_c, valid_d;
  logic en_a, en_b, en_c, en_d;

  // input register
  logic [KIND_BITS-1:0]         kind_a;
  logic signed [COORD_BITS-1:0] pos_a [NUM_AXES];
  logic signed [COORD_BITS-1:0] far_a [NUM_AXES];
  logic [RAD_W-1:0]             radius_a;

  // lane stage
  logic [KIND_BITS-1:0]         kind_b;
  logic signed [PROD_W-1:0]     prod_lo [NUM_AXES];
  logic signed [PROD_W-1:0]     prod_hi [NUM_AXES];
  logic signed [CMP_W-1:0]      thr_front_b;
  logic signed [CMP_W-1:0]      thr_behind_b;
  logic signed [CMP_W-1:0]      dref_ext;
  logic signed [CMP_W-1:0]      band;

  merge_ctl_t                   merge_ctl;
  logic [SIDE_BITS-1:0]         side;

  // stage enables: a stage loads when empty or when the next one moves
  assign en_d          = !valid_d || m_axis_tready;
  assign en_c          = !valid_c || en_d;
  assign en_b          = !valid_b || en_c;
  assign en_a          = !valid_a || en_b;
  assign s_axis_tready = en_a;
  assign cfg_ready     = 1'b1;

  assign merge_ctl.sum_en = en_c;
  assign merge_ctl.cmp_en = en_d;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        normal[i] <= '0;
      end
      plane_offset <= '0;
      tolerance    <= TOL_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORMAL_X:  normal[0]    <= cfg_data[NORMAL_BITS-1:0];
        REG_NORMAL_Y:  normal[1]    <= cfg_data[NORMAL_BITS-1:0];
        REG_NORMAL_Z:  normal[2]    <= cfg_data[NORMAL_BITS-1:0];
        REG_OFFSET:    plane_offset <= cfg_data[COORD_BITS-1:0];
        REG_TOLERANCE: tolerance    <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else begin
      if (en_a) valid_a <= s_axis_tvalid;
      if (en_b) valid_b <= valid_a;
      if (en_c) valid_c <= valid_b;
      if (en_d) valid_d <= valid_c;
    end
  end

  // input register: unpack the word
  always_ff @(posedge clk) begin
    if (en_a) begin
      kind_a <= s_axis_tuser;
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_a[i] <= s_axis_tdata[i*COORD_BITS +: COORD_BITS];
        far_a[i] <= s_axis_tdata[(i+NUM_AXES)*COORD_BITS +: COORD_BITS];
      end
      radius_a <= s_axis_tdata[2*NUM_AXES*COORD_BITS +: RAD_W];
    end
  end

  // thresholds: offset scaled to product units, widened by the band
  assign dref_ext = {{(CMP_W-DREF_W){plane_offset[COORD_BITS-1]}}, plane_offset,
                     {NORMAL_FRAC_BITS{1'b0}}};

  always_comb begin
    case (kind_a)
      KIND_POINT:  band = {{(CMP_W-TOL_BITS-NORMAL_FRAC_BITS){1'b0}}, tolerance,
                           {NORMAL_FRAC_BITS{1'b0}}};
      KIND_SPHERE: band = {{(CMP_W-RAD_W-NORMAL_FRAC_BITS){1'b0}}, radius_a,
                           {NORMAL_FRAC_BITS{1'b0}}};
      default:     band = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      kind_b       <= kind_a;
      thr_front_b  <= dref_ext + band;
      thr_behind_b <= dref_ext - band;
    end
  end

  // axis lanes
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    psc_lane #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (en_b),
      .kind    (kind_a),
      .normal  (normal[g]),
      .pos     (pos_a[g]),
      .far     (far_a[g]),
      .prod_lo (prod_lo[g]),
      .prod_hi (prod_hi[g])
    );
  end

  // sum and compare
  psc_merge #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .ctl        (merge_ctl),
    .kind       (kind_b),
    .prod_lo    (prod_lo),
    .prod_hi    (prod_hi),
    .thr_front  (thr_front_b),
    .thr_behind (thr_behind_b),
    .side       (side)
  );

  assign m_axis_tvalid = valid_d;
  assign m_axis_tdata  = {{(OUT_DATA_BITS-SIDE_BITS){1'b0}}, side};

  // a free output lets every stage move
  assert property (@(posedge clk) disable iff (rst) m_axis_tready |-> s_axis_tready)
    else $error("input held back although the output is free");

  // the front threshold never lies below the behind threshold
  assert property (@(posedge clk) disable iff (rst) valid_b |-> (thr_front_b >= thr_behind_b))
    else $error("threshold band inverted");

  // an accepted word lands in the input register
  assert property (@(posedge clk) disable iff (rst)
                   (s_axis_tvalid && s_axis_tready) |=> valid_a)
    else $error("accepted word lost at the input register");

  // only defined side codes leave the block
  assert property (@(posedge clk) disable iff (rst)
                   m_axis_tvalid |-> (side == SIDE_FRONT || side == SIDE_BEHIND ||
                                      side == SIDE_ON))
    else $error("undefined side code");

endmodule

`default_nettype wire
